### src/srtc_pkg.sv
// ============================================================================
// srtc_pkg
// Shared types and constants for the SNTP reply check and calendar block.
// ============================================================================
package srtc_pkg;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_RESP_ERR = 2'd1,
        STATUS_RANGE    = 2'd2
    } status_t;

    // Seconds since 2000-01-01 fit 31 bits over the full timestamp range
    localparam int SECS_W = 31;

    typedef struct packed {
        status_t             status;
        logic [SECS_W-1:0]   secs2000;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  STRATUM_LIMIT = 8'd15;
    localparam logic [2:0]  PROTO_VERSION = 3'd4;
    localparam logic [1:0]  LEAP_ALARM    = 2'd3;
    localparam logic [2:0]  MODE_SRV      = 3'd4;

    localparam logic [16:0] ZONE_RESET = 17'd7200;

    // NTP seconds at 2000-01-01 00:00:00
    localparam logic [34:0] NTP_SECS_2000 = 35'd3155673600;

    // Exact reciprocals: floor(x*M >> K) == floor(x/D) over the used range
    localparam logic [24:0] RECIP_675  = 25'd25451659;   // K = 34
    localparam logic [17:0] RECIP_3600 = 18'd149131;     // K = 29
    localparam logic [17:0] RECIP_60   = 18'd139811;     // K = 23
    localparam logic [13:0] RECIP_1461 = 14'd11484;      // K = 24
    localparam logic [14:0] RECIP_7    = 15'd18725;      // K = 17

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;
    localparam logic [14:0] WEEKDAY_BIAS  = 15'd6;       // 2000-01-01 was Saturday

    function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
        logic [8:0] base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (idx >= 4'd2))
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

### src/srtc_front.sv
// ============================================================================
// srtc_front
// Validate one reply header word, apply zone offset and rebase to 2000.
// ============================================================================
module srtc_front #(
    parameter int MIN_MESSAGE_BYTES = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                push,
    input  logic [10:0]         payload_length,
    input  logic [7:0]          hdr_flags,
    input  logic [7:0]          stratum,
    input  logic [31:0]         tx_seconds,
    input  logic [31:0]         tx_fraction,
    input  logic signed [16:0]  zone_offset,
    output logic                valid,
    output srtc_pkg::item_t     item
);

    logic             valid_reg;
    logic             valid_next;
    srtc_pkg::item_t  item_reg;
    srtc_pkg::item_t  item_next;
    logic             reply_ok;
    logic [34:0]      sum;

    always_comb
    begin
        reply_ok = (payload_length >= 11'(MIN_MESSAGE_BYTES))
                && (hdr_flags[7:6] != srtc_pkg::LEAP_ALARM)
                && (hdr_flags[5:3] == srtc_pkg::PROTO_VERSION)
                && (hdr_flags[2:0] == srtc_pkg::MODE_SRV)
                && (stratum != 8'd0)
                && (stratum <= srtc_pkg::STRATUM_LIMIT)
                && ((tx_seconds != 32'd0) || (tx_fraction != 32'd0));

        sum = {3'b000, tx_seconds} + {{18{zone_offset[16]}}, zone_offset}
            - srtc_pkg::NTP_SECS_2000;

        item_next.secs2000 = sum[srtc_pkg::SECS_W-1:0];
        if (!reply_ok)
        begin
            item_next.status = srtc_pkg::STATUS_RESP_ERR;
        end
        else if (sum[34])
        begin
            item_next.status = srtc_pkg::STATUS_RANGE;
        end
        else
        begin
            item_next.status = srtc_pkg::STATUS_OK;
        end

        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

### src/srtc_queue.sv
// ============================================================================
// srtc_queue
// Short FIFO between the classify front and the conversion pipeline.
// ============================================================================
module srtc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  srtc_pkg::item_t    push_item,
    input  logic               pop,
    output srtc_pkg::item_t    pop_item,
    output srtc_pkg::q_stat_t  stat
);

    localparam logic [srtc_pkg::QPTR_W-1:0] LAST_PTR =
        srtc_pkg::QPTR_W'(srtc_pkg::QUEUE_DEPTH - 1);
    localparam logic [srtc_pkg::QCNT_W-1:0] FULL_CNT =
        srtc_pkg::QCNT_W'(srtc_pkg::QUEUE_DEPTH);

    srtc_pkg::item_t                mem_reg [srtc_pkg::QUEUE_DEPTH];
    logic [srtc_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [srtc_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [srtc_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [srtc_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [srtc_pkg::QCNT_W-1:0]    count_reg;
    logic [srtc_pkg::QCNT_W-1:0]    count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item   = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);

    no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == FULL_CNT) && push |-> pop)
        else $error("push into full queue");

    no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

    count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");

endmodule

### src/srtc_back.sv
// ============================================================================
// srtc_back
// Six-stage pipeline: split seconds into days and time, days into date.
// ============================================================================
module srtc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  srtc_pkg::item_t  in_item,
    output logic             done,
    output logic [1:0]       status,
    output logic [7:0]       year_since_2000,
    output logic [3:0]       month,
    output logic [4:0]       day_of_month,
    output logic [2:0]       weekday,
    output logic [4:0]       hours,
    output logic [5:0]       minutes,
    output logic [5:0]       seconds_out
);

    logic [5:0] vld_reg;
    logic [5:0] vld_next;

    // stage 1
    srtc_pkg::status_t   st1_reg;
    logic [30:0]         u1_reg;
    logic [48:0]         pday_reg;
    logic [48:0]         pday_next;
    // stage 2
    srtc_pkg::status_t   st2_reg;
    logic [13:0]         d2_reg;
    logic [13:0]         d2_next;
    logic [16:0]         rem2_reg;
    logic [16:0]         rem2_next;
    logic [30:0]         dsec;
    logic [30:0]         rdiff;
    // stage 3
    srtc_pkg::status_t   st3_reg;
    logic [13:0]         d3_reg;
    logic [16:0]         rem3_reg;
    logic [14:0]         w3_reg;
    logic [14:0]         w3_next;
    logic [34:0]         ph_reg;
    logic [34:0]         ph_next;
    logic [34:0]         pm_reg;
    logic [34:0]         pm_next;
    logic [27:0]         pc_reg;
    logic [27:0]         pc_next;
    logic [29:0]         pw_reg;
    logic [29:0]         pw_next;
    // stage 4
    srtc_pkg::status_t   st4_reg;
    logic [4:0]          hr4_reg;
    logic [5:0]          mn4_reg;
    logic [5:0]          mn4_next;
    logic [5:0]          sc4_reg;
    logic [5:0]          sc4_next;
    logic [2:0]          wd4_reg;
    logic [2:0]          wd4_next;
    logic [3:0]          quad4_reg;
    logic [10:0]         r4_reg;
    logic [10:0]         r4_next;
    logic [10:0]         mtot;
    logic [10:0]         mdiff;
    logic [16:0]         sdiff;
    logic [13:0]         qdiff;
    logic [14:0]         wdiff;
    logic [12:0]         wq;
    // stage 5
    srtc_pkg::status_t   st5_reg;
    logic [4:0]          hr5_reg;
    logic [5:0]          mn5_reg;
    logic [5:0]          sc5_reg;
    logic [2:0]          wd5_reg;
    logic [7:0]          yr5_reg;
    logic [7:0]          yr5_next;
    logic [8:0]          doy5_reg;
    logic [8:0]          doy5_next;
    logic [10:0]         doy_wide;
    logic                leap5_reg;
    logic                leap5_next;
    logic [1:0]          yy;
    // stage 6 (output)
    srtc_pkg::status_t   st6_reg;
    logic [7:0]          yr6_reg;
    logic [7:0]          yr6_next;
    logic [3:0]          mo6_reg;
    logic [3:0]          mo6_next;
    logic [4:0]          dm6_reg;
    logic [4:0]          dm6_next;
    logic [2:0]          wd6_reg;
    logic [2:0]          wd6_next;
    logic [4:0]          hr6_reg;
    logic [4:0]          hr6_next;
    logic [5:0]          mn6_reg;
    logic [5:0]          mn6_next;
    logic [5:0]          sc6_reg;
    logic [5:0]          sc6_next;
    logic [3:0]          mo_idx;
    logic [8:0]          mo_base;
    logic [8:0]          dm_wide;

    assign vld_next = {vld_reg[4:0], in_valid};

    always_comb
    begin
        pday_next = 49'(in_item.secs2000[30:7]) * 49'(srtc_pkg::RECIP_675);

        d2_next   = pday_reg[47:34];
        dsec      = 31'(d2_next) * 31'(srtc_pkg::SECS_PER_DAY);
        rdiff     = u1_reg - dsec;
        rem2_next = rdiff[16:0];

        w3_next = 15'(d2_reg) + srtc_pkg::WEEKDAY_BIAS;
        ph_next = 35'(rem2_reg) * 35'(srtc_pkg::RECIP_3600);
        pm_next = 35'(rem2_reg) * 35'(srtc_pkg::RECIP_60);
        pc_next = 28'(d2_reg) * 28'(srtc_pkg::RECIP_1461);
        pw_next = 30'(w3_next) * 30'(srtc_pkg::RECIP_7);
    end

    always_comb
    begin
        mtot     = pm_reg[33:23];
        wq       = pw_reg[29:17];
        mdiff    = mtot - 11'(ph_reg[33:29]) * 11'd60;
        mn4_next = mdiff[5:0];
        sdiff    = rem3_reg - 17'(mtot) * 17'd60;
        sc4_next = sdiff[5:0];
        qdiff    = d3_reg - 14'(pc_reg[27:24]) * 14'(srtc_pkg::DAYS_PER_QUAD);
        r4_next  = qdiff[10:0];
        wdiff    = w3_reg - 15'(wq) * 15'd7;
        wd4_next = wdiff[2:0];
    end

    always_comb
    begin
        if (r4_reg < 11'd366)
        begin
            yy       = 2'd0;
            doy_wide = r4_reg;
        end
        else if (r4_reg < 11'd731)
        begin
            yy       = 2'd1;
            doy_wide = r4_reg - 11'd366;
        end
        else if (r4_reg < 11'd1096)
        begin
            yy       = 2'd2;
            doy_wide = r4_reg - 11'd731;
        end
        else
        begin
            yy       = 2'd3;
            doy_wide = r4_reg - 11'd1096;
        end
        leap5_next = (yy == 2'd0);
        doy5_next  = doy_wide[8:0];
        yr5_next   = {2'b00, quad4_reg, yy};
    end

    always_comb
    begin
        mo_idx  = 4'd0;
        mo_base = 9'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (doy5_reg >= srtc_pkg::month_start(4'(i), leap5_reg))
            begin
                mo_idx  = 4'(i);
                mo_base = srtc_pkg::month_start(4'(i), leap5_reg);
            end
        end
        dm_wide = doy5_reg - mo_base + 9'd1;

        if (st5_reg == srtc_pkg::STATUS_OK)
        begin
            yr6_next = yr5_reg;
            mo6_next = mo_idx + 4'd1;
            dm6_next = dm_wide[4:0];
            wd6_next = wd5_reg;
            hr6_next = hr5_reg;
            mn6_next = mn5_reg;
            sc6_next = sc5_reg;
        end
        else
        begin
            yr6_next = '0;
            mo6_next = '0;
            dm6_next = '0;
            wd6_next = '0;
            hr6_next = '0;
            mn6_next = '0;
            sc6_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st1_reg   <= in_item.status;
        u1_reg    <= in_item.secs2000;
        pday_reg  <= pday_next;

        st2_reg   <= st1_reg;
        d2_reg    <= d2_next;
        rem2_reg  <= rem2_next;

        st3_reg   <= st2_reg;
        d3_reg    <= d2_reg;
        rem3_reg  <= rem2_reg;
        w3_reg    <= w3_next;
        ph_reg    <= ph_next;
        pm_reg    <= pm_next;
        pc_reg    <= pc_next;
        pw_reg    <= pw_next;

        st4_reg   <= st3_reg;
        hr4_reg   <= ph_reg[33:29];
        mn4_reg   <= mn4_next;
        sc4_reg   <= sc4_next;
        wd4_reg   <= wd4_next;
        quad4_reg <= pc_reg[27:24];
        r4_reg    <= r4_next;

        st5_reg   <= st4_reg;
        hr5_reg   <= hr4_reg;
        mn5_reg   <= mn4_reg;
        sc5_reg   <= sc4_reg;
        wd5_reg   <= wd4_reg;
        yr5_reg   <= yr5_next;
        doy5_reg  <= doy5_next;
        leap5_reg <= leap5_next;

        st6_reg   <= st5_reg;
        yr6_reg   <= yr6_next;
        mo6_reg   <= mo6_next;
        dm6_reg   <= dm6_next;
        wd6_reg   <= wd6_next;
        hr6_reg   <= hr6_next;
        mn6_reg   <= mn6_next;
        sc6_reg   <= sc6_next;
    end

    assign done            = vld_reg[5];
    assign status          = st6_reg;
    assign year_since_2000 = yr6_reg;
    assign month           = mo6_reg;
    assign day_of_month    = dm6_reg;
    assign weekday         = wd6_reg;
    assign hours           = hr6_reg;
    assign minutes         = mn6_reg;
    assign seconds_out     = sc6_reg;

    latency_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##6 done)
        else $error("word lost in conversion pipeline");

    date_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == srtc_pkg::STATUS_OK) |->
            (month >= 4'd1) && (month <= 4'd12) && (day_of_month >= 5'd1)
            && (weekday <= 3'd6))
        else $error("illegal calendar fields");

    time_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == srtc_pkg::STATUS_OK) |->
            (hours <= 5'd23) && (minutes <= 6'd59) && (seconds_out <= 6'd59))
        else $error("illegal time of day");

    reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != srtc_pkg::STATUS_OK) |->
            (month == 4'd0) && (day_of_month == 5'd0) && (year_since_2000 == 8'd0))
        else $error("rejected word carries date");

endmodule

### src/sntp_reply_to_calendar.sv
// ============================================================================
// sntp_reply_to_calendar
// Check an SNTP reply header and convert its transmit time to a civil date.
//
//   channel   signals                                     handshake
//   -------   -----------------------------------------   ----------------
//   input     payload_length hdr_flags stratum             start && !busy
//             tx_seconds tx_fraction
//   result    status year_since_2000 month day_of_month    done, one cycle
//             weekday hours minutes seconds_out
//   config    cfg_wdata (zone offset, signed 17 bit)       cfg_we
//
// One word per cycle sustained while busy is low. Each result passes
// through the front register, the queue slot and the six-stage
// conversion pipeline (constant multiplies for the divisions by day,
// hour, minute, four-year cycle and week).
// Reset clears control state and loads the zone offset with 7200 s.
// The receiver cannot stall; busy rises only when the queue is full.
// ============================================================================
module sntp_reply_to_calendar #(
    parameter int MIN_MESSAGE_BYTES = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [10:0]         payload_length,
    input  logic [7:0]          hdr_flags,
    input  logic [7:0]          stratum,
    input  logic [31:0]         tx_seconds,
    input  logic [31:0]         tx_fraction,
    input  logic                cfg_we,
    input  logic signed [16:0]  cfg_wdata,
    output logic                done,
    output logic [1:0]          status,
    output logic [7:0]          year_since_2000,
    output logic [3:0]          month,
    output logic [4:0]          day_of_month,
    output logic [2:0]          weekday,
    output logic [4:0]          hours,
    output logic [5:0]          minutes,
    output logic [5:0]          seconds_out
);

    logic signed [16:0]  zone_reg;
    logic                front_valid;
    srtc_pkg::item_t     front_item;
    logic                load;
    logic                push;
    logic                pop;
    srtc_pkg::item_t     q_item;
    srtc_pkg::q_stat_t   q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= srtc_pkg::ZONE_RESET;
        end
        else if (cfg_we)
        begin
            zone_reg <= cfg_wdata;
        end
    end

    assign busy = front_valid && q_stat.full;
    assign load = start && !busy;
    assign push = front_valid && !q_stat.full;
    assign pop  = !q_stat.empty;

    srtc_front #(
        .MIN_MESSAGE_BYTES (MIN_MESSAGE_BYTES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .push           (push),
        .payload_length (payload_length),
        .hdr_flags      (hdr_flags),
        .stratum        (stratum),
        .tx_seconds     (tx_seconds),
        .tx_fraction    (tx_fraction),
        .zone_offset    (zone_reg),
        .valid          (front_valid),
        .item           (front_item)
    );

    srtc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .pop_item  (q_item),
        .stat      (q_stat)
    );

    srtc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (pop),
        .in_item         (q_item),
        .done            (done),
        .status          (status),
        .year_since_2000 (year_since_2000),
        .month           (month),
        .day_of_month    (day_of_month),
        .weekday         (weekday),
        .hours           (hours),
        .minutes         (minutes),
        .seconds_out     (seconds_out)
    );

endmodule

### tb/sv/sntp_reply_to_calendar_tb.sv
// ============================================================================
// sntp_reply_to_calendar_tb
// Self-checking bench for the SNTP reply check and calendar conversion.
// Drives reply headers as command words and predicts each result: header
// acceptance, zone offset, then the civil date and time. The date is found by
// walking years and months forward from 2000-01-01. The bench steps through
// several zone offsets, the 17-bit extremes among them, with random sender
// gaps and drains.
// ============================================================================
module sntp_reply_to_calendar_tb;

    localparam int     MIN_BYTES       = 48;
    localparam longint NTP_UNIX_EPOCH  = 64'd2208988800;
    localparam longint UNIX_AT_2000    = 64'd946684800;
    localparam longint NTP_AT_2000     = 64'd3155673600;
    localparam int     ITEMS_PER_PHASE = 160;
    localparam int     PHASES          = 8;
    localparam int     DRAIN_CYCLES    = 12;
    localparam int     STUCK_LIMIT     = 1000;

    localparam logic [7:0] GOOD_LVM = {2'd0, srtc_pkg::PROTO_VERSION, srtc_pkg::MODE_SRV};

    typedef struct packed {
        srtc_pkg::status_t status;
        logic [7:0]        year_since_2000;
        logic [3:0]        month;
        logic [4:0]        day_of_month;
        logic [2:0]        weekday;
        logic [4:0]        hours;
        logic [5:0]        minutes;
        logic [5:0]        seconds_out;
    } civil_stamp_t;

    class calendar_scoreboard;
        civil_stamp_t       pending[$];
        logic signed [16:0] zone_offset;
        int                 errors;
        int                 results_seen;
        int                 n_dated;
        int                 n_rejected;
        int                 n_range;

        function new();
            zone_offset  = srtc_pkg::ZONE_RESET;
            errors       = 0;
            results_seen = 0;
            n_dated      = 0;
            n_rejected   = 0;
            n_range      = 0;
        endfunction

        function bit is_leap(int yr);
            return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        endfunction

        function int days_in_month(int yr, int mon);
            case (mon)
                2:           return is_leap(yr) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:     return 31;
            endcase
        endfunction

        function civil_stamp_t to_civil(logic [10:0] len, logic [7:0] lvm, logic [7:0] strat,
                                        logic [31:0] secs, logic [31:0] frac);
            civil_stamp_t stamp;
            longint       unix_secs;
            longint       day_count;
            longint       sod;
            int           yr;
            int           mon;
            bit           hdr_ok;
            stamp  = '0;
            hdr_ok = (len >= MIN_BYTES) &&
                     (lvm[7:6] != srtc_pkg::LEAP_ALARM) &&
                     (lvm[5:3] == srtc_pkg::PROTO_VERSION) &&
                     (lvm[2:0] == srtc_pkg::MODE_SRV) &&
                     (strat != 8'd0) && (strat <= srtc_pkg::STRATUM_LIMIT) &&
                     ((secs != 32'd0) || (frac != 32'd0));
            if (!hdr_ok)
            begin
                stamp.status = srtc_pkg::STATUS_RESP_ERR;
                return stamp;
            end
            unix_secs = longint'(secs) + longint'(zone_offset) - NTP_UNIX_EPOCH;
            if (unix_secs < UNIX_AT_2000)
            begin
                stamp.status = srtc_pkg::STATUS_RANGE;
                return stamp;
            end
            unix_secs = unix_secs - UNIX_AT_2000;
            day_count = unix_secs / 86400;
            sod       = unix_secs % 86400;
            // 2000-01-01 was a Saturday
            stamp.weekday = 3'((day_count + 6) % 7);
            yr = 2000;
            while (day_count >= (is_leap(yr) ? 366 : 365))
            begin
                day_count = day_count - (is_leap(yr) ? 366 : 365);
                yr++;
            end
            if (yr > 2255)
            begin
                stamp = '0;
                stamp.status = srtc_pkg::STATUS_RANGE;
                return stamp;
            end
            mon = 1;
            while (day_count >= days_in_month(yr, mon))
            begin
                day_count = day_count - days_in_month(yr, mon);
                mon++;
            end
            stamp.status          = srtc_pkg::STATUS_OK;
            stamp.year_since_2000 = 8'(yr - 2000);
            stamp.month           = 4'(mon);
            stamp.day_of_month    = 5'(day_count + 1);
            stamp.hours           = 5'(sod / 3600);
            stamp.minutes         = 6'((sod / 60) % 60);
            stamp.seconds_out     = 6'(sod % 60);
            return stamp;
        endfunction

        function void note_reply(logic [10:0] len, logic [7:0] lvm, logic [7:0] strat,
                                 logic [31:0] secs, logic [31:0] frac);
            pending.push_back(to_civil(len, lvm, strat, secs, frac));
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH result %0d: %s", results_seen, msg);
            errors++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
            begin
                report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
            end
        endtask

        task check_result(civil_stamp_t got);
            civil_stamp_t want;
            results_seen++;
            if (pending.size() == 0)
            begin
                report_mismatch("result with no reply outstanding");
                return;
            end
            want = pending.pop_front();
            case (want.status)
                srtc_pkg::STATUS_OK:       n_dated++;
                srtc_pkg::STATUS_RESP_ERR: n_rejected++;
                default:                   n_range++;
            endcase
            check_field("status", got.status, want.status);
            check_field("year_since_2000", got.year_since_2000, want.year_since_2000);
            check_field("month", got.month, want.month);
            check_field("day_of_month", got.day_of_month, want.day_of_month);
            check_field("weekday", got.weekday, want.weekday);
            check_field("hours", got.hours, want.hours);
            check_field("minutes", got.minutes, want.minutes);
            check_field("seconds_out", got.seconds_out, want.seconds_out);
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [10:0]        payload_length;
    logic [7:0]         hdr_flags;
    logic [7:0]         stratum;
    logic [31:0]        tx_seconds;
    logic [31:0]        tx_fraction;
    logic               cfg_we;
    logic signed [16:0] cfg_wdata;
    logic               done;
    logic [1:0]         status;
    logic [7:0]         year_since_2000;
    logic [3:0]         month;
    logic [4:0]         day_of_month;
    logic [2:0]         weekday;
    logic [4:0]         hours;
    logic [5:0]         minutes;
    logic [5:0]         seconds_out;

    calendar_scoreboard sb;
    int                 stuck_cycles;
    int                 zones_used;

    sntp_reply_to_calendar #(
        .MIN_MESSAGE_BYTES(MIN_BYTES)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .payload_length (payload_length),
        .hdr_flags      (hdr_flags),
        .stratum        (stratum),
        .tx_seconds     (tx_seconds),
        .tx_fraction    (tx_fraction),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .done           (done),
        .status         (status),
        .year_since_2000(year_since_2000),
        .month          (month),
        .day_of_month   (day_of_month),
        .weekday        (weekday),
        .hours          (hours),
        .minutes        (minutes),
        .seconds_out    (seconds_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        civil_stamp_t got;
        if (rst_n && done)
        begin
            got.status          = srtc_pkg::status_t'(status);
            got.year_since_2000 = year_since_2000;
            got.month           = month;
            got.day_of_month    = day_of_month;
            got.weekday         = weekday;
            got.hours           = hours;
            got.minutes         = minutes;
            got.seconds_out     = seconds_out;
            sb.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic send_reply(input logic [10:0] len, input logic [7:0] lvm,
                              input logic [7:0] strat, input logic [31:0] secs,
                              input logic [31:0] frac);
        @(negedge clk);
        start          <= 1'b1;
        payload_length <= len;
        hdr_flags      <= lvm;
        stratum        <= strat;
        tx_seconds     <= secs;
        tx_fraction    <= frac;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        sb.note_reply(len, lvm, strat, secs, frac);
    endtask

    task automatic idle_sender();
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            gap = 0;
        else if (roll < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // hold off until every outstanding word has come back
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_zone(input logic signed [16:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        sb.zone_offset = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        zones_used++;
    endtask

    task automatic send_random_reply();
        logic [10:0] len;
        logic [7:0]  lvm;
        logic [7:0]  strat;
        logic [31:0] secs;
        logic [31:0] frac;
        logic [2:0]  field;
        int          roll;
        roll  = $urandom_range(0, 99);
        len   = ($urandom_range(0, 1) == 0) ? 11'($urandom_range(MIN_BYTES, 68))
                                            : 11'($urandom_range(MIN_BYTES, 2047));
        lvm   = {2'($urandom_range(0, 2)), srtc_pkg::PROTO_VERSION, srtc_pkg::MODE_SRV};
        strat = 8'($urandom_range(1, srtc_pkg::STRATUM_LIMIT));
        case ($urandom_range(0, 3))
            0, 1: secs = $urandom;
            2:    secs = 32'(NTP_AT_2000 - longint'(sb.zone_offset)
                             + longint'($urandom_range(0, 400000)) - 200000);
            default: secs = $urandom_range(32'hFFFFFFFF, 32'(NTP_AT_2000));
        endcase
        frac = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
        if (roll >= 90)
        begin
            len   = 11'($urandom);
            lvm   = 8'($urandom);
            strat = 8'($urandom);
            secs  = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        end
        else if (roll >= 70)
        begin
            case ($urandom_range(0, 5))
                0: len = 11'($urandom_range(0, MIN_BYTES - 1));
                1: lvm[7:6] = srtc_pkg::LEAP_ALARM;
                2:
                begin
                    field = 3'($urandom_range(0, 6));
                    lvm[5:3] = (field >= srtc_pkg::PROTO_VERSION) ? field + 3'd1 : field;
                end
                3:
                begin
                    field = 3'($urandom_range(0, 6));
                    lvm[2:0] = (field >= srtc_pkg::MODE_SRV) ? field + 3'd1 : field;
                end
                4: strat = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(16, 255));
                default:
                begin
                    secs = 32'd0;
                    frac = 32'd0;
                end
            endcase
        end
        send_reply(len, lvm, strat, secs, frac);
    endtask

    initial
    begin
        logic signed [16:0] zone;
        bit                 burst;
        sb             = new();
        zones_used     = 1;
        burst          = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        payload_length = '0;
        hdr_flags      = '0;
        stratum        = '0;
        tx_seconds     = '0;
        tx_fraction    = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
            begin
                // first second of 2000 and the one before it
                send_reply(11'd48, GOOD_LVM, 8'd1, 32'(NTP_AT_2000 - sb.zone_offset), 32'd0);
                send_reply(11'd48, GOOD_LVM, 8'd1, 32'(NTP_AT_2000 - sb.zone_offset - 1),
                           32'hFFFFFFFF);
                send_reply(11'd48, GOOD_LVM, 8'd15, 32'd0, 32'd1);
                send_reply(11'd48, GOOD_LVM, 8'd1, 32'd0, 32'd0);
                send_reply(11'd2047, GOOD_LVM, 8'd15, 32'hFFFFFFFF, 32'hFFFFFFFF);
                send_reply(11'd47, GOOD_LVM, 8'd1, 32'hE0000000, 32'd5);
                send_reply(11'd0, GOOD_LVM, 8'd1, 32'hE0000000, 32'd5);
                send_reply(11'd68, {2'd1, srtc_pkg::PROTO_VERSION, srtc_pkg::MODE_SRV}, 8'd2,
                           32'hE1234567, 32'd0);
                send_reply(11'd68, {2'd2, srtc_pkg::PROTO_VERSION, srtc_pkg::MODE_SRV}, 8'd2,
                           32'hE1234567, 32'd0);
                send_reply(11'd68,
                           {srtc_pkg::LEAP_ALARM, srtc_pkg::PROTO_VERSION, srtc_pkg::MODE_SRV},
                           8'd2, 32'hE1234567, 32'd0);
                send_reply(11'd48, {2'd0, 3'd3, srtc_pkg::MODE_SRV}, 8'd3, 32'hE1234567, 32'd1);
                send_reply(11'd48, {2'd0, 3'd5, srtc_pkg::MODE_SRV}, 8'd3, 32'hE1234567, 32'd1);
                send_reply(11'd48, {2'd0, srtc_pkg::PROTO_VERSION, 3'd3}, 8'd3,
                           32'hE1234567, 32'd1);
                send_reply(11'd48, {2'd0, srtc_pkg::PROTO_VERSION, 3'd5}, 8'd3,
                           32'hE1234567, 32'd1);
                send_reply(11'd48, 8'hFF, 8'd3, 32'hE1234567, 32'd1);
                send_reply(11'd48, 8'h00, 8'd3, 32'hE1234567, 32'd1);
                send_reply(11'd48, GOOD_LVM, 8'd0, 32'hE1234567, 32'd1);
                send_reply(11'd48, GOOD_LVM, 8'd16, 32'hE1234567, 32'd1);
                send_reply(11'd48, GOOD_LVM, 8'd255, 32'hE1234567, 32'd1);
                // leap day 2024-02-29 12:34:56, then the last second of 2000
                send_reply(11'd48, GOOD_LVM, 8'd1,
                           32'(NTP_AT_2000 + 8825 * 86400 + 45296 - sb.zone_offset), 32'd7);
                send_reply(11'd48, GOOD_LVM, 8'd1,
                           32'(NTP_AT_2000 + 365 * 86400 + 86399 - sb.zone_offset), 32'd7);
            end
            else
            begin
                case (phase)
                    1:       zone = -17'sd50400;
                    2:       zone = 17'sd50400;
                    3:       zone = 17'sd0;
                    4:       zone = 17'h10000;
                    5:       zone = 17'h0FFFF;
                    default: zone = 17'($urandom);
                endcase
                wait_drained();
                write_zone(zone);
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (i % 40 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                if (!burst)
                    idle_sender();
                if ($urandom_range(0, 199) == 0)
                    wait_drained();
                send_random_reply();
            end
        end

        wait_drained();
        $display("Checked %0d results: %0d dated, %0d rejected, %0d out of range",
                 sb.results_seen, sb.n_dated, sb.n_rejected, sb.n_range);
        $display("Zone offsets exercised: %0d, including both 17-bit extremes", zones_used);
        if (sb.errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
